// ----- design/tpf_pkg.sv -----
// Shared constants, types and helpers for the trapezoid profile fraction block.
`timescale 1ns / 1ps
package tpf_pkg;
    localparam int POS_W   = 32;               // position width
    localparam int LEN_W   = POS_W - 1;        // ramp length width
    localparam int FRAC_W  = 16;               // fractional bits of the result
    localparam int OUT_W   = FRAC_W + 1;       // result width, one is 1<<FRAC_W
    localparam int OPD_W   = POS_W + 2;        // multiplier operand width
    localparam int DIV_W   = 2 * POS_W + 2;    // dividend and divisor width
    localparam int NSTEP   = FRAC_W + 1;       // quotient bits
    localparam int IDX_W   = 2;
    localparam int S_TDATA_W = ((POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] REG_START = 2'd0;
    localparam logic [IDX_W-1:0] REG_END   = 2'd1;
    localparam logic [IDX_W-1:0] REG_ACCEL = 2'd2;
    localparam logic [IDX_W-1:0] REG_BRAKE = 2'd3;

    localparam logic [OUT_W-1:0] FRAC_ONE = OUT_W'(1) << FRAC_W;

    typedef struct packed {
        logic             valid;
        logic             bypass;   // result is forced, divider output ignored
        logic [OUT_W-1:0] frac;     // forced result
        logic             bad;
    } t_ctl;

    typedef struct packed {
        logic [DIV_W-1:0] p;
        logic [DIV_W-1:0] q;
        logic [OUT_W-1:0] res;
    } t_div;

    // One restoring step: shift, compare, subtract.
    function automatic t_div div_step(t_div v, logic first);
        t_div o;
        o = v;
        if (!first) begin
            o.p = v.p << 1;
        end
        o.res = v.res << 1;
        if (o.p >= o.q) begin
            o.p = o.p - o.q;
            o.res[0] = 1'b1;
        end
        return o;
    endfunction
endpackage

// ----- design/tpf_front.sv -----
// Range checks, segment decode and multiplier operand selection (two stages).
`timescale 1ns / 1ps
module tpf_front import tpf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_ce,
    input  logic                    i_valid,
    input  logic signed [POS_W-1:0] i_position,
    input  logic signed [POS_W-1:0] i_start,
    input  logic signed [POS_W-1:0] i_end,
    input  logic [LEN_W-1:0]        i_accel,
    input  logic [LEN_W-1:0]        i_brake,
    output t_ctl                    o_ctl,
    output logic [OPD_W-1:0]        o_p0,
    output logic [OPD_W-1:0]        o_p1,
    output logic [OPD_W-1:0]        o_q0,
    output logic [OPD_W-1:0]        o_q1,
    output logic                    o_sub
);
    t_ctl               r_ctl1, n_ctl1, r_ctl2, n_ctl2;
    logic [POS_W-1:0]   r_r, r_c;
    logic [LEN_W-1:0]   r_a, r_b;
    logic [OPD_W-1:0]   r_p0, r_p1, r_q0, r_q1, n_p0, n_p1, n_q0, n_q1;
    logic               r_sub, n_sub;
    logic               w_end, w_start;
    logic [POS_W:0]     w_ab, w_rb;
    logic [OPD_W-1:0]   w_d;

    assign w_end   = i_position >= i_end;
    assign w_start = i_position <= i_start;

    always_comb begin
        n_ctl1.valid  = i_valid;
        n_ctl1.bypass = w_end || w_start;
        n_ctl1.frac   = w_end ? FRAC_ONE : '0;
        n_ctl1.bad    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
        end else if (i_ce) begin
            r_ctl1 <= n_ctl1;
        end
        if (i_ce) begin
            r_r <= POS_W'(i_end - i_start);
            r_c <= POS_W'(i_position - i_start);
            r_a <= i_accel;
            r_b <= i_brake;
        end
    end

    assign w_ab = {2'b0, r_a} + {2'b0, r_b};
    assign w_rb = {1'b0, r_r} - {2'b0, r_b};
    assign w_d  = {1'b0, r_r, 1'b0} - OPD_W'(w_ab);

    always_comb begin
        n_ctl2 = r_ctl1;
        if (!r_ctl1.bypass && ({1'b0, r_r} < w_ab)) begin
            n_ctl2.bypass = 1'b1;
            n_ctl2.bad    = 1'b1;
            n_ctl2.frac   = '0;
        end
        n_sub = 1'b0;
        if ((r_a != '0) && (r_c <= POS_W'(r_a))) begin
            // accelerating ramp: c^2 / (A*D)
            n_p0 = OPD_W'(r_c);
            n_p1 = OPD_W'(r_c);
            n_q0 = OPD_W'(r_a);
            n_q1 = w_d;
        end else if ({1'b0, r_c} <= w_rb) begin
            // cruise: (2c - A) / D
            n_p0 = {1'b0, r_c, 1'b0} - OPD_W'(r_a);
            n_p1 = OPD_W'(1);
            n_q0 = w_d;
            n_q1 = OPD_W'(1);
        end else begin
            // braking ramp: 1 - (R-c)^2 / (B*D)
            n_p0 = OPD_W'(r_r - r_c);
            n_p1 = OPD_W'(r_r - r_c);
            n_q0 = OPD_W'(r_b);
            n_q1 = w_d;
            n_sub = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2.valid <= 1'b0;
        end else if (i_ce) begin
            r_ctl2 <= n_ctl2;
        end
        if (i_ce) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_q0  <= n_q0;
            r_q1  <= n_q1;
            r_sub <= n_sub;
        end
    end

    assign o_ctl = r_ctl2;
    assign o_p0  = r_p0;
    assign o_p1  = r_p1;
    assign o_q0  = r_q0;
    assign o_q1  = r_q1;
    assign o_sub = r_sub;
endmodule

// ----- design/tpf_mul.sv -----
// Numerator and denominator products, then the braking-ramp complement.
`timescale 1ns / 1ps
module tpf_mul import tpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  t_ctl             i_ctl,
    input  logic [OPD_W-1:0] i_p0,
    input  logic [OPD_W-1:0] i_p1,
    input  logic [OPD_W-1:0] i_q0,
    input  logic [OPD_W-1:0] i_q1,
    input  logic             i_sub,
    output t_ctl             o_ctl,
    output logic [DIV_W-1:0] o_p,
    output logic [DIV_W-1:0] o_q
);
    t_ctl             r_ctl1, r_ctl2;
    logic [DIV_W-1:0] r_pm, r_qm, r_p, r_q;
    logic             r_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
        end else if (i_ce) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
        if (i_ce) begin
            r_pm  <= DIV_W'(i_p0 * i_p1);
            r_qm  <= DIV_W'(i_q0 * i_q1);
            r_sub <= i_sub;
            r_p   <= r_sub ? (r_qm - r_pm) : r_pm;
            r_q   <= r_qm;
        end
    end

    assign o_ctl = r_ctl2;
    assign o_p   = r_p;
    assign o_q   = r_q;
endmodule

// ----- design/tpf_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tpf_div import tpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  t_ctl             i_ctl,
    input  logic [DIV_W-1:0] i_p,
    input  logic [DIV_W-1:0] i_q,
    output t_ctl             o_ctl,
    output logic [OUT_W-1:0] o_res
);
    t_ctl r_ctl [NSTEP];
    t_div r_v   [NSTEP];
    t_div w_in;

    always_comb begin
        w_in.p   = i_p;
        w_in.q   = i_q;
        w_in.res = '0;
    end

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k].valid <= 1'b0;
            end else if (i_ce) begin
                r_ctl[k] <= (k == 0) ? i_ctl : r_ctl[(k == 0) ? 0 : k - 1];
            end
            if (i_ce) begin
                r_v[k] <= div_step((k == 0) ? w_in : r_v[(k == 0) ? 0 : k - 1], k == 0);
            end
        end
    end

    assign o_ctl = r_ctl[NSTEP-1];
    assign o_res = r_v[NSTEP-1].res;
endmodule

// ----- design/trapezoid_profile_fraction.sv -----
// Top level: configuration registers, pipeline and output register.
`timescale 1ns / 1ps
// Returns the completed Q1.16 fraction of a trapezoidal move for each Q16.16
// position. One transaction is taken every cycle while the output is not stalled;
// each result passes through two decode stages, two multiply stages, seventeen
// divider stages (one quotient bit per stage) and one output register.
// The whole pipeline holds while a result waits at the output. Configuration
// writes take effect at once and must be made with no transaction in flight.
module trapezoid_profile_fraction import tpf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] position
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // [16:0] fraction, rest zero
    output logic                 m_axis_tuser,  // [0] profile_invalid
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data
);
    logic signed [POS_W-1:0] r_start, r_end;
    logic [LEN_W-1:0]        r_accel, r_brake;
    logic                    w_ce;
    t_ctl                    w_ctl_f, w_ctl_m, w_ctl_d;
    logic [OPD_W-1:0]        w_p0, w_p1, w_q0, w_q1;
    logic                    w_sub;
    logic [DIV_W-1:0]        w_p, w_q;
    logic [OUT_W-1:0]        w_res;
    logic                    r_valid;
    logic [OUT_W-1:0]        r_frac;
    logic                    r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_end   <= POS_W'(65536);
            r_accel <= '0;
            r_brake <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START: r_start <= i_cfg_data;
                REG_END:   r_end   <= i_cfg_data;
                REG_ACCEL: r_accel <= i_cfg_data[LEN_W-1:0];
                REG_BRAKE: r_brake <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // advance everything unless a result is stuck at the output
    assign w_ce          = !r_valid || m_axis_tready;
    assign s_axis_tready = w_ce;

    tpf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(w_ce),
        .i_valid(s_axis_tvalid), .i_position(s_axis_tdata[POS_W-1:0]),
        .i_start(r_start), .i_end(r_end), .i_accel(r_accel), .i_brake(r_brake),
        .o_ctl(w_ctl_f), .o_p0(w_p0), .o_p1(w_p1), .o_q0(w_q0), .o_q1(w_q1),
        .o_sub(w_sub)
    );

    tpf_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(w_ce), .i_ctl(w_ctl_f),
        .i_p0(w_p0), .i_p1(w_p1), .i_q0(w_q0), .i_q1(w_q1), .i_sub(w_sub),
        .o_ctl(w_ctl_m), .o_p(w_p), .o_q(w_q)
    );

    tpf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ce(w_ce), .i_ctl(w_ctl_m),
        .i_p(w_p), .i_q(w_q), .o_ctl(w_ctl_d), .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ce) begin
            r_valid <= w_ctl_d.valid;
        end
        if (w_ce) begin
            r_frac <= w_ctl_d.bypass ? w_ctl_d.frac : w_res;
            r_bad  <= w_ctl_d.bad;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_frac);
    assign m_axis_tuser  = r_bad;
endmodule

// ----- design/tpf_checker.sv -----
// Port-level checks for the trapezoid profile fraction block.
`timescale 1ns / 1ps
module tpf_checker import tpf_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= M_TDATA_W'(FRAC_ONE)))
        else $error("fraction above one");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid profile with nonzero fraction");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");
endmodule

bind trapezoid_profile_fraction tpf_checker u_tpf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
